FILE: src/bqa_pkg.sv
// Shared types and constants for the bounded queue with average unit.
`timescale 1ns / 1ps

package bqa_pkg;

  localparam int unsigned IdW     = 16;
  localparam int unsigned YearW   = 12;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 3;
  localparam int unsigned BitW    = $clog2(YearW);

  localparam logic [BitW-1:0] DivLastBit = BitW'(YearW - 1);

  localparam logic [StatusW-1:0] StInserted = 2'd0;
  localparam logic [StatusW-1:0] StRemoved  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty    = 2'd2;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqRemove = 1'b1;

  typedef enum logic [2:0] {
    StateIdle,
    StatePop,
    StatePush,
    StateDiv,
    StateDone
  } bqa_state_e;

  typedef struct packed {
    logic latch;
    logic pop;
    logic capture;
    logic set_empty;
    logic push;
    logic div_step;
  } bqa_cmd_t;

  typedef struct packed {
    logic req_remove;
    logic full;
    logic empty;
    logic div_last;
  } bqa_sts_t;

endpackage

FILE: src/bounded_queue_with_average_unit.sv
// Top level of the bounded queue with average unit.
`timescale 1ns / 1ps

// Holds up to CAPACITY entries of identifier and year in arrival order, one
// request at a time. A remove passes through the pop and done states; an
// insert passes through pop, push, division and done, the restoring divider
// forming the mean of the stored years one quotient bit per cycle. The oldest
// entry is read from a registered memory port, so every request passes through
// the pop state for that read before the queue is updated. The next request is
// accepted in the cycle after the result transfer.
module bounded_queue_with_average_unit
  import bqa_pkg::*;
#(
  parameter int unsigned CAPACITY = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [IdW-1:0]     item_id_i,
  input  logic [YearW-1:0]   item_year_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [YearW-1:0]   mean_year_o,
  output logic [IdW-1:0]     removed_id_o,
  output logic [YearW-1:0]   removed_year_o,
  output logic [FillW-1:0]   fill_count_o
);

  bqa_cmd_t cmd;
  bqa_sts_t sts;

  bqa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bqa_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_type_i),
    .item_id_i      (item_id_i),
    .item_year_i    (item_year_i),
    .status_o       (status_o),
    .mean_year_o    (mean_year_o),
    .removed_id_o   (removed_id_o),
    .removed_year_o (removed_year_o),
    .fill_count_o   (fill_count_o)
  );

endmodule

FILE: src/bqa_ctrl.sv
// Controller state machine that sequences pop, push, division and result transfer.
`timescale 1ns / 1ps

module bqa_ctrl
  import bqa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  bqa_sts_t sts_i,
  output bqa_cmd_t cmd_o
);

  bqa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StateIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StatePop;
        end
      end
      StatePop: begin
        if (sts_i.req_remove) begin
          if (sts_i.empty) begin
            cmd_o.set_empty = 1'b1;
          end else begin
            cmd_o.pop     = 1'b1;
            cmd_o.capture = 1'b1;
          end
          state_d = StateDone;
        end else begin
          cmd_o.pop = sts_i.full;
          state_d   = StatePush;
        end
      end
      StatePush: begin
        cmd_o.push = 1'b1;
        state_d    = StateDiv;
      end
      StateDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StateDone;
        end
      end
      StateDone: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

endmodule

FILE: src/bqa_dp.sv
// Datapath with the entry storage, queue pointers, year sum and mean divider.
`timescale 1ns / 1ps

module bqa_dp
  import bqa_pkg::*;
#(
  parameter int unsigned CAPACITY = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bqa_cmd_t           cmd_i,
  output bqa_sts_t           sts_o,
  input  logic               req_type_i,
  input  logic [IdW-1:0]     item_id_i,
  input  logic [YearW-1:0]   item_year_i,
  output logic [StatusW-1:0] status_o,
  output logic [YearW-1:0]   mean_year_o,
  output logic [IdW-1:0]     removed_id_o,
  output logic [YearW-1:0]   removed_year_o,
  output logic [FillW-1:0]   fill_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = YearW + CW;

  logic [IdW-1:0]   id_mem [CAPACITY];
  logic [YearW-1:0] year_mem [CAPACITY];

  logic               req_q;
  logic [IdW-1:0]     id_q;
  logic [YearW-1:0]   year_q;
  logic [IdW-1:0]     rd_id_q;
  logic [YearW-1:0]   rd_year_q;
  logic [AW-1:0]      head_q;
  logic [CW-1:0]      count_q;
  logic [SW-1:0]      sum_q;
  logic [SW-1:0]      rem_q;
  logic [YearW-1:0]   quo_q;
  logic [BitW-1:0]    bit_q;
  logic [StatusW-1:0] status_q;
  logic [IdW-1:0]     rid_q;
  logic [YearW-1:0]   ryear_q;

  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_next;
  logic [SW-1:0] sum_push;
  logic [SW:0]   trial;
  logic          ge;

  always_comb begin
    tail_sum = {1'b0, head_q} + (AW + 1)'(count_q);
    if (tail_sum >= (AW + 1)'(CAPACITY)) begin
      tail_sum = tail_sum - (AW + 1)'(CAPACITY);
    end
    tail = tail_sum[AW-1:0];
  end

  assign head_next = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
  assign sum_push  = sum_q + SW'(year_q);
  assign trial     = (SW + 1)'(count_q) << bit_q;
  assign ge        = ({1'b0, rem_q} >= trial);

  assign sts_o.req_remove = (req_q == ReqRemove);
  assign sts_o.full       = (count_q == CW'(CAPACITY));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.div_last   = (bit_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (cmd_i.pop) begin
      head_q  <= head_next;
      count_q <= count_q - 1'b1;
      sum_q   <= sum_q - SW'(rd_year_q);
    end else if (cmd_i.push) begin
      count_q <= count_q + 1'b1;
      sum_q   <= sum_push;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_id_q   <= id_mem[head_q];
    rd_year_q <= year_mem[head_q];
    if (cmd_i.push) begin
      id_mem[tail]   <= id_q;
      year_mem[tail] <= year_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= req_type_i;
      id_q     <= item_id_i;
      year_q   <= item_year_i;
      status_q <= StInserted;
      quo_q    <= '0;
      rid_q    <= '0;
      ryear_q  <= '0;
    end
    if (cmd_i.set_empty) begin
      status_q <= StEmpty;
    end
    if (cmd_i.capture) begin
      status_q <= StRemoved;
      rid_q    <= rd_id_q;
      ryear_q  <= rd_year_q;
    end
    if (cmd_i.push) begin
      rem_q <= sum_push;
      bit_q <= DivLastBit;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[YearW-2:0], ge};
      bit_q <= bit_q - 1'b1;
      if (ge) begin
        rem_q <= rem_q - trial[SW-1:0];
      end
    end
  end

  assign status_o       = status_q;
  assign mean_year_o    = quo_q;
  assign removed_id_o   = rid_q;
  assign removed_year_o = ryear_q;
  assign fill_count_o   = FillW'(count_q);

endmodule
